// File: rtl/dllm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_pkg: shared types, constants and microcode for the linked list manager
// Holds the command codes, the control word layout, the microcode program and
// the dispatch table that maps a command to its first step.
// ----------------------------------------------------------------------------
package dllm_pkg;

   localparam int NODES  = 256;
   localparam int NODE_W = 8;
   localparam int ADDR_W = $clog2(NODES);
   localparam int CNT_W  = 8;
   localparam int STEP_W = 5;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [2:0] {
      CMD_INSERT_HEAD   = 3'd0,
      CMD_INSERT_AFTER  = 3'd1,
      CMD_INSERT_BEFORE = 3'd2,
      CMD_APPEND        = 3'd3,
      CMD_REMOVE        = 3'd4,
      CMD_POP           = 3'd5,
      CMD_READ_HEAD     = 3'd6
   } cmd_type;

   // Conditional jump tests.
   typedef enum logic [2:0] {
      J_NONE, J_BAD_ITEM, J_BAD_PAIR, J_EMPTY, J_UNLINKED
   } jmp_type;

   // Operation on one link table port.
   typedef enum logic [1:0] {
      M_IDLE, M_READ, M_WRITE, M_WRITE_NZ
   } mop_type;

   // Operand select, used for both link table addresses and write data.
   typedef enum logic [2:0] {
      S_ZERO, S_ITEM, S_ANCHOR, S_FIRST, S_LAST, S_RD_NEXT, S_RD_PREV
   } sel_type;

   typedef enum logic [2:0] {
      H_KEEP, H_ITEM, H_ITEM_IF_EMPTY, H_ITEM_IF_ANCHOR, H_RDN_IF_ITEM, H_RDN
   } head_op_type;

   typedef enum logic [2:0] {
      T_KEEP, T_ITEM, T_ITEM_IF_EMPTY, T_ITEM_IF_ANCHOR, T_RDP_IF_ITEM, T_ZERO_IF_RDN_ZERO
   } tail_op_type;

   typedef enum logic [1:0] {
      C_KEEP, C_INC, C_DEC
   } cnt_op_type;

   typedef enum logic [1:0] {
      N_ZERO, N_FIRST, N_ITEM
   } node_sel_type;

   typedef enum logic [1:0] {
      SQ_CLEAR, SQ_IDLE, SQ_RUN
   } sq_state_type;

   typedef struct packed {
      jmp_type      jump;
      step_type     jmp_to;
      mop_type      nx_op;
      sel_type      nx_addr;
      sel_type      nx_data;
      mop_type      pv_op;
      sel_type      pv_addr;
      sel_type      pv_data;
      head_op_type  head_op;
      tail_op_type  tail_op;
      cnt_op_type   cnt_op;
      logic         hold_first;
      logic         done;
      logic         fail;
      node_sel_type node_sel;
   } cw_type;

   // Sequencer to datapath.
   typedef struct packed {
      cw_type   cw;
      logic     exec;
      logic     clear;
      addr_type clr_addr;
   } ctl_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic bad_item;
      logic bad_pair;
      logic empty;
      logic unlinked;
   } flags_type;

   typedef struct packed {
      logic     status;
      node_type node;
      cnt_type  count;
   } res_type;

   // Program entry points.
   localparam step_type ST_FAIL       = 5'd0;
   localparam step_type ST_READ_HEAD  = 5'd1;
   localparam step_type ST_INS_HEAD   = 5'd2;
   localparam step_type ST_INS_AFTER  = 5'd4;
   localparam step_type ST_INS_BEFORE = 5'd7;
   localparam step_type ST_APPEND     = 5'd10;
   localparam step_type ST_REMOVE     = 5'd12;
   localparam step_type ST_POP        = 5'd15;

   localparam cw_type CW_NOP = '{
      jump:       J_NONE,
      jmp_to:     ST_FAIL,
      nx_op:      M_IDLE,
      nx_addr:    S_ZERO,
      nx_data:    S_ZERO,
      pv_op:      M_IDLE,
      pv_addr:    S_ZERO,
      pv_data:    S_ZERO,
      head_op:    H_KEEP,
      tail_op:    T_KEEP,
      cnt_op:     C_KEEP,
      hold_first: 1'b0,
      done:       1'b0,
      fail:       1'b0,
      node_sel:   N_ZERO
   };

   function automatic logic valid_node(node_type n);
      return (n != '0) && (32'(n) < NODES);
   endfunction

   function automatic step_type entry_step(logic [2:0] cmd);
      step_type s;
      unique case (cmd)
         CMD_INSERT_HEAD:   s = ST_INS_HEAD;
         CMD_INSERT_AFTER:  s = ST_INS_AFTER;
         CMD_INSERT_BEFORE: s = ST_INS_BEFORE;
         CMD_APPEND:        s = ST_APPEND;
         CMD_REMOVE:        s = ST_REMOVE;
         CMD_POP:           s = ST_POP;
         CMD_READ_HEAD:     s = ST_READ_HEAD;
         default:           s = ST_FAIL;
      endcase
      return s;
   endfunction

   // The microcode program. Reads land in the read data registers for the step
   // after them; a taken jump cancels every effect of its step.
   function automatic cw_type ucode(step_type s);
      cw_type cw;
      cw = CW_NOP;
      unique case (s)
         5'd0: begin
            cw.done = 1'b1;
            cw.fail = 1'b1;
         end
         5'd1: begin
            cw.done     = 1'b1;
            cw.node_sel = N_FIRST;
         end
         // Insert at head.
         5'd2: begin
            cw.jump = J_BAD_ITEM;
            cw.nx_op = M_WRITE; cw.nx_addr = S_ITEM; cw.nx_data = S_FIRST;
            cw.pv_op = M_WRITE; cw.pv_addr = S_ITEM; cw.pv_data = S_ZERO;
         end
         5'd3: begin
            cw.pv_op = M_WRITE_NZ; cw.pv_addr = S_FIRST; cw.pv_data = S_ITEM;
            cw.head_op = H_ITEM;
            cw.tail_op = T_ITEM_IF_EMPTY;
            cw.cnt_op  = C_INC;
            cw.done    = 1'b1;
         end
         // Insert after anchor.
         5'd4: begin
            cw.jump = J_BAD_PAIR;
            cw.nx_op = M_READ; cw.nx_addr = S_ANCHOR;
         end
         5'd5: begin
            cw.nx_op = M_WRITE; cw.nx_addr = S_ITEM; cw.nx_data = S_RD_NEXT;
            cw.pv_op = M_WRITE; cw.pv_addr = S_ITEM; cw.pv_data = S_ANCHOR;
         end
         5'd6: begin
            cw.nx_op = M_WRITE;    cw.nx_addr = S_ANCHOR;  cw.nx_data = S_ITEM;
            cw.pv_op = M_WRITE_NZ; cw.pv_addr = S_RD_NEXT; cw.pv_data = S_ITEM;
            cw.tail_op = T_ITEM_IF_ANCHOR;
            cw.cnt_op  = C_INC;
            cw.done    = 1'b1;
         end
         // Insert before anchor.
         5'd7: begin
            cw.jump = J_BAD_PAIR;
            cw.pv_op = M_READ; cw.pv_addr = S_ANCHOR;
         end
         5'd8: begin
            cw.pv_op = M_WRITE; cw.pv_addr = S_ITEM; cw.pv_data = S_RD_PREV;
            cw.nx_op = M_WRITE; cw.nx_addr = S_ITEM; cw.nx_data = S_ANCHOR;
         end
         5'd9: begin
            cw.pv_op = M_WRITE;    cw.pv_addr = S_ANCHOR;  cw.pv_data = S_ITEM;
            cw.nx_op = M_WRITE_NZ; cw.nx_addr = S_RD_PREV; cw.nx_data = S_ITEM;
            cw.head_op = H_ITEM_IF_ANCHOR;
            cw.cnt_op  = C_INC;
            cw.done    = 1'b1;
         end
         // Append at tail.
         5'd10: begin
            cw.jump = J_BAD_ITEM;
            cw.pv_op = M_WRITE; cw.pv_addr = S_ITEM; cw.pv_data = S_LAST;
            cw.nx_op = M_WRITE; cw.nx_addr = S_ITEM; cw.nx_data = S_ZERO;
         end
         5'd11: begin
            cw.nx_op = M_WRITE_NZ; cw.nx_addr = S_LAST; cw.nx_data = S_ITEM;
            cw.tail_op = T_ITEM;
            cw.head_op = H_ITEM_IF_EMPTY;
            cw.cnt_op  = C_INC;
            cw.done    = 1'b1;
         end
         // Remove.
         5'd12: begin
            cw.jump = J_BAD_ITEM;
            cw.nx_op = M_READ; cw.nx_addr = S_ITEM;
            cw.pv_op = M_READ; cw.pv_addr = S_ITEM;
         end
         5'd13: begin
            cw.jump = J_UNLINKED;
            cw.nx_op = M_WRITE_NZ; cw.nx_addr = S_RD_PREV; cw.nx_data = S_RD_NEXT;
            cw.pv_op = M_WRITE_NZ; cw.pv_addr = S_RD_NEXT; cw.pv_data = S_RD_PREV;
            cw.head_op = H_RDN_IF_ITEM;
            cw.tail_op = T_RDP_IF_ITEM;
         end
         5'd14: begin
            cw.nx_op = M_WRITE; cw.nx_addr = S_ITEM; cw.nx_data = S_ZERO;
            cw.pv_op = M_WRITE; cw.pv_addr = S_ITEM; cw.pv_data = S_ZERO;
            cw.cnt_op = C_DEC;
            cw.done   = 1'b1;
         end
         // Pop head.
         5'd15: begin
            cw.jump = J_EMPTY;
            cw.nx_op = M_READ; cw.nx_addr = S_FIRST;
            cw.hold_first = 1'b1;
         end
         5'd16: begin
            cw.pv_op = M_WRITE_NZ; cw.pv_addr = S_RD_NEXT; cw.pv_data = S_ZERO;
            cw.head_op = H_RDN;
            cw.tail_op = T_ZERO_IF_RDN_ZERO;
         end
         5'd17: begin
            cw.nx_op = M_WRITE; cw.nx_addr = S_ITEM; cw.nx_data = S_ZERO;
            cw.pv_op = M_WRITE; cw.pv_addr = S_ITEM; cw.pv_data = S_ZERO;
            cw.cnt_op   = C_DEC;
            cw.done     = 1'b1;
            cw.node_sel = N_ITEM;
         end
         default: begin
            cw.done = 1'b1;
            cw.fail = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

// File: rtl/dllm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_seq: microcode sequencer
// Step counter over the microcode table, dispatch on the command, conditional
// jumps on datapath flags, and the link table clearing sweep after reset.
// ----------------------------------------------------------------------------
module dllm_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           cmd,
   input  dllm_pkg::flags_type  flags,
   input  logic                 out_blocked,
   output logic                 idle,
   output dllm_pkg::ctl_type    ctl
);

   dllm_pkg::sq_state_type state_ff, state_in;
   dllm_pkg::step_type     step_ff, step_in;
   dllm_pkg::addr_type     clr_ff, clr_in;
   dllm_pkg::cw_type       cw;
   logic                   taken;
   logic                   blocked;
   logic                   exec;
   logic                   clear;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dllm_pkg::SQ_CLEAR;
         step_ff  <= dllm_pkg::ST_FAIL;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         clr_ff   <= clr_in;
      end
   end

   always_comb begin
      cw = dllm_pkg::ucode(step_ff);
      unique case (cw.jump)
         dllm_pkg::J_NONE:     taken = 1'b0;
         dllm_pkg::J_BAD_ITEM: taken = flags.bad_item;
         dllm_pkg::J_BAD_PAIR: taken = flags.bad_pair;
         dllm_pkg::J_EMPTY:    taken = flags.empty;
         dllm_pkg::J_UNLINKED: taken = flags.unlinked;
         default:              taken = 1'b0;
      endcase
      // A finishing step waits while the output register is still full.
      blocked  = cw.done && out_blocked;

      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      exec     = 1'b0;
      clear    = 1'b0;
      idle     = 1'b0;
      unique case (state_ff)
         dllm_pkg::SQ_CLEAR: begin
            clear  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = dllm_pkg::SQ_IDLE;
            end
         end
         dllm_pkg::SQ_IDLE: begin
            idle = 1'b1;
            if (start) begin
               step_in  = dllm_pkg::entry_step(cmd);
               state_in = dllm_pkg::SQ_RUN;
            end
         end
         dllm_pkg::SQ_RUN: begin
            if (!blocked) begin
               if (taken) begin
                  step_in = cw.jmp_to;
               end else begin
                  exec = 1'b1;
                  if (cw.done) begin
                     state_in = dllm_pkg::SQ_IDLE;
                  end else begin
                     step_in = step_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = dllm_pkg::SQ_IDLE;
         end
      endcase

      ctl.cw       = cw;
      ctl.exec     = exec;
      ctl.clear    = clear;
      ctl.clr_addr = clr_ff;
   end

endmodule

// File: rtl/dllm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dllm_dp: list datapath
// Next and previous link memories, head, tail and length registers, the
// latched request, and the flags and result that the control word selects.
// ----------------------------------------------------------------------------
module dllm_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  dllm_pkg::node_type   in_item,
   input  dllm_pkg::node_type   in_anchor,
   input  dllm_pkg::ctl_type    ctl,
   output dllm_pkg::flags_type  flags,
   output dllm_pkg::res_type    res
);

   dllm_pkg::node_type next_mem [dllm_pkg::NODES];
   dllm_pkg::node_type prev_mem [dllm_pkg::NODES];

   dllm_pkg::node_type item_ff, anchor_ff;
   dllm_pkg::node_type rd_next_ff, rd_prev_ff;
   dllm_pkg::node_type first_ff, first_in;
   dllm_pkg::node_type last_ff, last_in;
   dllm_pkg::cnt_type  count_ff, count_in;

   dllm_pkg::node_type nx_a, nx_d, pv_a, pv_d;
   logic               nx_we, nx_re, pv_we, pv_re;
   dllm_pkg::addr_type nx_idx, pv_idx;
   dllm_pkg::node_type nx_wd, pv_wd;

   function automatic dllm_pkg::node_type pick(
      dllm_pkg::sel_type  s,
      dllm_pkg::node_type it,
      dllm_pkg::node_type an,
      dllm_pkg::node_type fi,
      dllm_pkg::node_type la,
      dllm_pkg::node_type rn,
      dllm_pkg::node_type rp
   );
      dllm_pkg::node_type v;
      unique case (s)
         dllm_pkg::S_ZERO:    v = '0;
         dllm_pkg::S_ITEM:    v = it;
         dllm_pkg::S_ANCHOR:  v = an;
         dllm_pkg::S_FIRST:   v = fi;
         dllm_pkg::S_LAST:    v = la;
         dllm_pkg::S_RD_NEXT: v = rn;
         dllm_pkg::S_RD_PREV: v = rp;
         default:             v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      nx_a = pick(ctl.cw.nx_addr, item_ff, anchor_ff, first_ff, last_ff, rd_next_ff, rd_prev_ff);
      nx_d = pick(ctl.cw.nx_data, item_ff, anchor_ff, first_ff, last_ff, rd_next_ff, rd_prev_ff);
      pv_a = pick(ctl.cw.pv_addr, item_ff, anchor_ff, first_ff, last_ff, rd_next_ff, rd_prev_ff);
      pv_d = pick(ctl.cw.pv_data, item_ff, anchor_ff, first_ff, last_ff, rd_next_ff, rd_prev_ff);

      // The clearing sweep owns both ports until it is done.
      nx_we  = ctl.clear || (ctl.exec && ((ctl.cw.nx_op == dllm_pkg::M_WRITE) ||
               ((ctl.cw.nx_op == dllm_pkg::M_WRITE_NZ) && (nx_a != '0))));
      pv_we  = ctl.clear || (ctl.exec && ((ctl.cw.pv_op == dllm_pkg::M_WRITE) ||
               ((ctl.cw.pv_op == dllm_pkg::M_WRITE_NZ) && (pv_a != '0))));
      nx_re  = ctl.exec && (ctl.cw.nx_op == dllm_pkg::M_READ);
      pv_re  = ctl.exec && (ctl.cw.pv_op == dllm_pkg::M_READ);
      nx_idx = ctl.clear ? ctl.clr_addr : nx_a[dllm_pkg::ADDR_W-1:0];
      pv_idx = ctl.clear ? ctl.clr_addr : pv_a[dllm_pkg::ADDR_W-1:0];
      nx_wd  = ctl.clear ? '0 : nx_d;
      pv_wd  = ctl.clear ? '0 : pv_d;
   end

   always_ff @(posedge clock) begin
      if (nx_we) begin
         next_mem[nx_idx] <= nx_wd;
      end
      if (nx_re) begin
         rd_next_ff <= next_mem[nx_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (pv_we) begin
         prev_mem[pv_idx] <= pv_wd;
      end
      if (pv_re) begin
         rd_prev_ff <= prev_mem[pv_idx];
      end
   end

   always_comb begin
      first_in = first_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (ctl.exec) begin
         unique case (ctl.cw.head_op)
            dllm_pkg::H_KEEP:           first_in = first_ff;
            dllm_pkg::H_ITEM:           first_in = item_ff;
            dllm_pkg::H_ITEM_IF_EMPTY:  first_in = (first_ff == '0) ? item_ff : first_ff;
            dllm_pkg::H_ITEM_IF_ANCHOR: first_in = (first_ff == anchor_ff) ? item_ff : first_ff;
            dllm_pkg::H_RDN_IF_ITEM:    first_in = (first_ff == item_ff) ? rd_next_ff : first_ff;
            dllm_pkg::H_RDN:            first_in = rd_next_ff;
            default:                    first_in = first_ff;
         endcase
         unique case (ctl.cw.tail_op)
            dllm_pkg::T_KEEP:             last_in = last_ff;
            dllm_pkg::T_ITEM:             last_in = item_ff;
            dllm_pkg::T_ITEM_IF_EMPTY:    last_in = (last_ff == '0) ? item_ff : last_ff;
            dllm_pkg::T_ITEM_IF_ANCHOR:   last_in = (last_ff == anchor_ff) ? item_ff : last_ff;
            dllm_pkg::T_RDP_IF_ITEM:      last_in = (last_ff == item_ff) ? rd_prev_ff : last_ff;
            dllm_pkg::T_ZERO_IF_RDN_ZERO: last_in = (rd_next_ff == '0) ? '0 : last_ff;
            default:                      last_in = last_ff;
         endcase
         unique case (ctl.cw.cnt_op)
            dllm_pkg::C_KEEP: count_in = count_ff;
            dllm_pkg::C_INC:  count_in = count_ff + 1'b1;
            dllm_pkg::C_DEC:  count_in = count_ff - 1'b1;
            default:          count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '0;
         count_ff <= '0;
      end else begin
         first_ff <= first_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
   end

   // Pop parks the old head in the item register for its final clear step.
   always_ff @(posedge clock) begin
      if (start) begin
         item_ff   <= in_item;
         anchor_ff <= in_anchor;
      end else if (ctl.exec && ctl.cw.hold_first) begin
         item_ff   <= first_ff;
      end
   end

   always_comb begin
      flags.bad_item = !dllm_pkg::valid_node(item_ff);
      flags.bad_pair = !dllm_pkg::valid_node(item_ff) || !dllm_pkg::valid_node(anchor_ff) ||
                       (item_ff == anchor_ff);
      flags.empty    = (first_ff == '0);
      flags.unlinked = !((first_ff == item_ff) || (last_ff == item_ff) ||
                         (rd_prev_ff != '0) || (rd_next_ff != '0));

      res.status = ctl.cw.fail;
      res.count  = count_in;
      unique case (ctl.cw.node_sel)
         dllm_pkg::N_ZERO:  res.node = '0;
         dllm_pkg::N_FIRST: res.node = first_ff;
         dllm_pkg::N_ITEM:  res.node = item_ff;
         default:           res.node = '0;
      endcase
   end

endmodule

// File: rtl/doubly_linked_list_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// doubly_linked_list_manager: one doubly linked list over a pool of 255 nodes
// Top level: request handshake, microcode sequencer, datapath, result register.
// ----------------------------------------------------------------------------
// A request (req_cmd, req_item, req_anchor) is taken when req_valid and
// req_ready are both high; every request returns exactly one response
// (rsp_status, rsp_node, rsp_count) on the rsp_ valid/ready channel.
// Requests are handled one at a time by a microcode program whose steps each
// use one port of the next and of the previous link memory. After the request
// is taken, read head takes 1 step, insert at head and append 2, insert
// after, insert before, remove and pop 3; a request that fails its check
// takes 2 steps, except a remove of an unlinked node, which takes 3 (command
// code 7 takes 1). The response is registered at the end of the last step,
// and req_ready returns in that same cycle, so the next request can be
// taken only once the last step of the one before has run.
// After reset the link memories are cleared one entry per cycle; req_ready
// stays low until all 256 are clear. Head, tail and length clear at once.
// While a response waits on rsp_ready the block still takes the next request
// and runs it up to its last step, which then holds until the output
// register frees up.
// ----------------------------------------------------------------------------
module doubly_linked_list_manager (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_item,
   input  logic [7:0] req_anchor,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_status,
   output logic [7:0] rsp_node,
   output logic [7:0] rsp_count
);

   logic                 idle;
   logic                 start;
   logic                 out_blocked;
   logic                 load;
   dllm_pkg::ctl_type    ctl;
   dllm_pkg::flags_type  flags;
   dllm_pkg::res_type    res;

   logic                 rsp_valid_ff, rsp_valid_in;
   dllm_pkg::res_type    rsp_ff;

   assign req_ready   = idle;
   assign start       = req_valid && idle;
   assign out_blocked = rsp_valid_ff && !rsp_ready;
   assign load        = ctl.exec && ctl.cw.done;

   dllm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .cmd         (req_cmd),
      .flags       (flags),
      .out_blocked (out_blocked),
      .idle        (idle),
      .ctl         (ctl)
   );

   dllm_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .in_item   (req_item),
      .in_anchor (req_anchor),
      .ctl       (ctl),
      .flags     (flags),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_ff.status;
   assign rsp_node   = rsp_ff.node;
   assign rsp_count  = rsp_ff.count;

endmodule
